@@ design/sitdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sitdt_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitdt_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   localparam logic [3:0] BCD_ADJUST_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJUST       = 4'd3;
   localparam logic [3:0] BCD_MAX_DIGIT    = 4'd9;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_DONE
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SIGN,
      EMIT_DIGITS
   } emit_state_type;

   typedef struct packed {
      logic valid;
   } bcd_handshake_type;

endpackage

@@ design/sitdt_front.sv @@
// ----------------------------------------------------------------------------
// sitdt_front
// Accepts input transactions, splits each value into sign and magnitude and
// writes the pair into a two-entry queue that feeds the converter.
// ----------------------------------------------------------------------------
module sitdt_front #(
   parameter int VALUE_WIDTH = sitdt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [63:0]            req_value,
   output logic                   req_full,
   input  logic                   q_pop,
   output logic                   q_empty,
   output logic                   q_negative,
   output logic [VALUE_WIDTH-1:0] q_magnitude
);

   localparam int DATA_WIDTH = VALUE_WIDTH + 1;

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic [DATA_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   negative;
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign raw      = req_value[VALUE_WIDTH-1:0];
   assign negative = raw[VALUE_WIDTH-1];
   assign wr_data  = {negative, negative ? (~raw + 1'b1) : raw};

   assign req_full = (count_ff == 2'd2);
   assign q_empty  = (count_ff == 2'd0);
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && !q_empty;

   assign q_negative  = entry_ff[rd_ptr_ff][DATA_WIDTH-1];
   assign q_magnitude = entry_ff[rd_ptr_ff][VALUE_WIDTH-1:0];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ design/sitdt_conv.sv @@
// ----------------------------------------------------------------------------
// sitdt_conv
// Bit-serial binary to BCD converter. Each cycle it adjusts every BCD digit
// and shifts one magnitude bit in, most significant bit first.
// ----------------------------------------------------------------------------
module sitdt_conv #(
   parameter int VALUE_WIDTH = sitdt_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGITS      = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  logic                            q_negative,
   input  logic [VALUE_WIDTH-1:0]          q_magnitude,
   output logic                            q_pop,
   output sitdt_pkg::bcd_handshake_type    bcd_hs_out,
   input  logic                            bcd_take,
   output logic                            bcd_negative,
   output logic [4*DIGITS-1:0]             bcd_digits
);

   localparam int BCD_WIDTH = 4 * DIGITS;
   localparam int CW        = $clog2(VALUE_WIDTH);

   sitdt_pkg::conv_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic                   neg_ff, neg_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= sitdt_pkg::BCD_ADJUST_LIMIT) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + sitdt_pkg::BCD_ADJUST;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sitdt_pkg::CONV_IDLE: begin
            if (!q_empty) begin
               state_in = sitdt_pkg::CONV_RUN;
            end
         end
         sitdt_pkg::CONV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = sitdt_pkg::CONV_DONE;
            end
         end
         sitdt_pkg::CONV_DONE: begin
            if (bcd_take) begin
               state_in = sitdt_pkg::CONV_IDLE;
            end
         end
         default: begin
            state_in = sitdt_pkg::CONV_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop            = 1'b0;
      bcd_hs_out.valid = 1'b0;
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      case (state_ff)
         sitdt_pkg::CONV_IDLE: begin
            q_pop  = !q_empty;
            mag_in = q_magnitude;
            neg_in = q_negative;
            bcd_in = '0;
            cnt_in = CW'(VALUE_WIDTH - 1);
         end
         sitdt_pkg::CONV_RUN: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         sitdt_pkg::CONV_DONE: begin
            bcd_hs_out.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign bcd_negative = neg_ff;
   assign bcd_digits   = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitdt_pkg::CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   a_done_mag_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == sitdt_pkg::CONV_DONE |-> mag_ff == '0)
      else $error("magnitude not fully shifted at end of conversion");

   a_load_on_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == sitdt_pkg::CONV_RUN && bcd_ff == '0)
      else $error("converter did not start after taking a queue entry");

endmodule

@@ design/sitdt_emit.sv @@
// ----------------------------------------------------------------------------
// sitdt_emit
// Turns a finished BCD word into characters: an optional minus sign, then
// the digits from the leading nonzero one down, through an output register.
// ----------------------------------------------------------------------------
module sitdt_emit #(
   parameter int DIGITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sitdt_pkg::bcd_handshake_type bcd_hs_in,
   output logic                         bcd_take,
   input  logic                         bcd_negative,
   input  logic [4*DIGITS-1:0]          bcd_digits,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);

   localparam int IW = $clog2(DIGITS);

   sitdt_pkg::emit_state_type state_ff, state_in;

   logic [4*DIGITS-1:0] bcd_ff, bcd_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       top_digit;
   logic [3:0]          cur_digit;
   logic                advance;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_character_ff, rsp_character_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [7:0]          next_char;
   logic                next_last;

   always_comb begin
      top_digit = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_digits[4*d +: 4] != 4'd0) begin
            top_digit = IW'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign advance   = (state_ff != sitdt_pkg::EMIT_IDLE) && (!rsp_valid_ff || rsp_pop);
   assign bcd_take  = (state_ff == sitdt_pkg::EMIT_IDLE) && bcd_hs_in.valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sitdt_pkg::EMIT_IDLE: begin
            if (bcd_hs_in.valid) begin
               state_in = bcd_negative ? sitdt_pkg::EMIT_SIGN : sitdt_pkg::EMIT_DIGITS;
            end
         end
         sitdt_pkg::EMIT_SIGN: begin
            if (advance) begin
               state_in = sitdt_pkg::EMIT_DIGITS;
            end
         end
         sitdt_pkg::EMIT_DIGITS: begin
            if (advance && idx_ff == '0) begin
               state_in = sitdt_pkg::EMIT_IDLE;
            end
         end
         default: begin
            state_in = sitdt_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_comb begin
      bcd_in    = bcd_ff;
      idx_in    = idx_ff;
      next_char = sitdt_pkg::CHAR_ZERO + {4'd0, cur_digit};
      next_last = 1'b0;
      case (state_ff)
         sitdt_pkg::EMIT_IDLE: begin
            if (bcd_take) begin
               bcd_in = bcd_digits;
               idx_in = top_digit;
            end
         end
         sitdt_pkg::EMIT_SIGN: begin
            next_char = sitdt_pkg::CHAR_MINUS;
         end
         sitdt_pkg::EMIT_DIGITS: begin
            next_last = (idx_ff == '0);
            if (advance && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = next_char;
         rsp_last_in      = next_last;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitdt_pkg::EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff           <= bcd_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_character_ff == sitdt_pkg::CHAR_MINUS |-> !rsp_last_ff)
      else $error("minus sign marked as the final character");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_character_ff == sitdt_pkg::CHAR_MINUS ||
         (rsp_character_ff >= sitdt_pkg::CHAR_ZERO &&
          rsp_character_ff <= sitdt_pkg::CHAR_NINE))
      else $error("character is neither a digit nor a minus sign");

   a_digit_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == sitdt_pkg::EMIT_DIGITS |-> cur_digit <= sitdt_pkg::BCD_MAX_DIGIT)
      else $error("BCD digit out of range");

endmodule

@@ design/signed_int_to_decimal_text_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_core
// Converts signed integers into their decimal ASCII text, one character per
// result transaction.
// ----------------------------------------------------------------------------
// Each value pushed on req_ produces its decimal text on rsp_, most
// significant digit first, with a leading minus for negative values; rsp_last
// marks the final character. The front stage splits the value into sign and
// magnitude and holds up to two transactions in a queue. A bit-serial
// shift-and-add-3 converter then turns each magnitude into BCD, one value at
// a time. The character stage emits one character per cycle while the reader
// pops, through an output register, while the next conversion runs.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_core #(
   parameter int VALUE_WIDTH = sitdt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

   logic                         q_pop;
   logic                         q_empty;
   logic                         q_negative;
   logic [VALUE_WIDTH-1:0]       q_magnitude;
   sitdt_pkg::bcd_handshake_type bcd_hs;
   logic                         bcd_take;
   logic                         bcd_negative;
   logic [4*DIGITS-1:0]          bcd_digits;

   sitdt_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_value   (req_value),
      .req_full    (req_full),
      .q_pop       (q_pop),
      .q_empty     (q_empty),
      .q_negative  (q_negative),
      .q_magnitude (q_magnitude)
   );

   sitdt_conv #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_conv (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_negative   (q_negative),
      .q_magnitude  (q_magnitude),
      .q_pop        (q_pop),
      .bcd_hs_out   (bcd_hs),
      .bcd_take     (bcd_take),
      .bcd_negative (bcd_negative),
      .bcd_digits   (bcd_digits)
   );

   sitdt_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .bcd_hs_in     (bcd_hs),
      .bcd_take      (bcd_take),
      .bcd_negative  (bcd_negative),
      .bcd_digits    (bcd_digits),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

@@ dv/signed_int_to_decimal_text_core_tb.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_core_tb
// Self-checking testbench for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
// Signed 64-bit values are pushed into the core. The run starts with a
// directed set of edge values, such as zero, the extremes and powers of ten,
// and then a large random mix of sizes and signs. A local model turns every
// accepted value into its expected characters. A monitor compares each popped
// character and its last flag with the oldest expected one. Both sides stall
// at random, with stretches at full rate, a slow reader and one drain pause.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam int END_CYCLES = 150;
   localparam int MAX_PRINTED_ERRORS = 40;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [63:0] req_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   text_char_type expected_text[$];
   text_char_type oldest_char;
   int error_count = 0;
   int values_converted = 0;
   int negatives_converted = 0;
   int chars_checked = 0;
   int idle_cycles = 0;
   int send_gap_max = 5;
   int pop_stall_max = 5;

   signed_int_to_decimal_text_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_value(req_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   task automatic report_mismatch(input string message);
      if (error_count < MAX_PRINTED_ERRORS) begin
         $display("%0t ns: mismatch: %s", $time, message);
      end
      error_count++;
   endtask

   function automatic void predict_text(input logic [63:0] value);
      logic [63:0]   width_mask;
      logic [63:0]   raw;
      logic [63:0]   magnitude;
      logic          negative;
      logic [3:0]    digits[20];
      int            digit_count;
      text_char_type entry;
      width_mask = (VALUE_WIDTH == 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      raw = value & width_mask;
      negative = raw[VALUE_WIDTH - 1];
      magnitude = negative ? ((~raw + 64'd1) & width_mask) : raw;
      digit_count = 0;
      do begin
         digits[digit_count] = 4'(magnitude % 64'd10);
         digit_count++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 64'd0);
      if (negative) begin
         entry.character = sitdt_pkg::CHAR_MINUS;
         entry.last = 1'b0;
         expected_text.push_back(entry);
         negatives_converted++;
      end
      for (int i = digit_count - 1; i >= 0; i--) begin
         entry.character = sitdt_pkg::CHAR_ZERO + 8'(digits[i]);
         entry.last = (i == 0);
         expected_text.push_back(entry);
      end
      values_converted++;
   endfunction

   // Accepted values are predicted before results are checked in the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            predict_text(req_value);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character %0d", rsp_character));
            end else begin
               oldest_char = expected_text.pop_front();
               chars_checked++;
               if (rsp_character !== oldest_char.character) begin
                  report_mismatch($sformatf("character got %0d expected %0d",
                     rsp_character, oldest_char.character));
               end
               if (rsp_last !== oldest_char.last) begin
                  report_mismatch($sformatf("last got %b expected %b on character %0d",
                     rsp_last, oldest_char.last, oldest_char.character));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("signed_int_to_decimal_text_core_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int stall;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, pop_stall_max);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         @(negedge clock);
      end
   end

   // The push stays high after a transaction so that back-to-back sends
   // never lower and raise it in the same step.
   task automatic send_value(input logic [63:0] value);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic wait_until_drained();
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_value();
      logic [63:0] value;
      logic [63:0] power;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: value = value >> $urandom_range(0, 63);
         2: value = 64'($urandom_range(0, 1000));
         default: begin
            power = 64'd1;
            repeat ($urandom_range(0, 18)) power = power * 64'd10;
            value = power + 64'($urandom_range(0, 2)) - 64'd1;
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         value = -value;
      end
      send_value(value);
   endtask

   task automatic test_directed_values();
      logic [63:0] edge_values[20] = '{
         64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
         -64'd100, 64'd1234567890, -64'd987654321, 64'd999999999999999999,
         64'd1000000000000000000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
         64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
         64'hAAAA_AAAA_AAAA_AAAA, 64'd8
      };
      foreach (edge_values[i]) begin
         send_value(edge_values[i]);
      end
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_random_value();
   endtask

   task automatic test_full_rate(input int count);
      send_gap_max = 0;
      pop_stall_max = 0;
      repeat (count) send_random_value();
      send_gap_max = 5;
      pop_stall_max = 5;
   endtask

   task automatic test_slow_reader(input int count);
      send_gap_max = 0;
      repeat (count) send_random_value();
      send_gap_max = 5;
   endtask

   task automatic test_pause_until_drained(input int count);
      repeat (count) send_random_value();
      stop_sending();
      wait_until_drained();
      repeat (count) send_random_value();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_values();
      test_random_values(200);
      test_full_rate(40);
      test_slow_reader(30);
      test_pause_until_drained(15);
      test_random_values(120);

      stop_sending();
      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
      end

      $display("Converted %0d values (%0d negative) and checked %0d characters,",
         values_converted, negatives_converted, chars_checked);
      $display("with edge values, random sizes, full-rate and stalled stretches.");
      if (error_count == 0) begin
         $display("signed_int_to_decimal_text_core_tb: done, clean");
      end else begin
         $display("signed_int_to_decimal_text_core_tb: done, errors");
      end
      $finish;
   end

endmodule
